// ----- sv/apt_pkg.sv -----
package apt_pkg;

    // Fixed-point format of coordinates and coefficients
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Port field width of one coordinate
    localparam int DATA_W = 32;

    // Configuration register file
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int ADDR_W   = IDX_W + 3;

    // Datapath widths: a product, or a translation term scaled up by FRAC_BITS
    localparam int EXT_W  = (COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS;
    localparam int PROD_W = COORD_WIDTH + EXT_W;
    localparam int SUM_W  = PROD_W + 2;

    typedef enum logic [1:0] {
        ACT_AFFINE = 2'd0,
        ACT_FULL   = 2'd1,
        ACT_LINEAR = 2'd2
    } action_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef coord_t [3:0] vec_t;
    typedef vec_t   [3:0] mat_t;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef prod_t [3:0] prow_t;
    typedef prow_t [3:0] pmat_t;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t  [1:0] pair_t;
    typedef pair_t [3:0] pairs_t;

    // Per-stage control that travels with the data
    typedef struct packed {
        logic valid;
        logic full;
        logic affine;
    } tag_t;

    // Identity matrix after reset
    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    function automatic coord_t to_coord(input logic [DATA_W-1:0] f);
        return coord_t'(f[COORD_WIDTH-1:0]);
    endfunction

endpackage

// ----- sv/affine_point_transform.sv -----
// Channel  | Ports                 | Contents (lowest bits first)
// ---------+-----------------------+---------------------------------------
// input    | s_tvalid/tready/tdata | tdata: x_in, y_in, z_in, w_in
//          | s_tuser               | tuser: action (0 affine, 1 full, 2 linear)
// result   | m_tvalid/tready/tdata | tdata: x_out, y_out, z_out, w_out
//          | m_tuser               | tuser: clipped
// config   | APB, 64-bit data      | reg i at byte address 8*i
//
// One point per cycle sustained while m_tready stays high. Four register stages:
// input register, multiplier array (16 products), pair adders, final
// add/round/saturate into the output register, which drives m_tvalid.
// aresetn (synchronous, active low) empties the pipeline and loads the
// identity matrix. Each stage holds while its successor is full and stalled;
// bubbles close up, so input is taken while a result waits at the output.
// Items with action 3 are taken and dropped at the input register.
module affine_point_transform (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [4*apt_pkg::DATA_W-1:0]  s_tdata,   // x_in, y_in, z_in, w_in
    input  logic [1:0]                    s_tuser,   // action
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [4*apt_pkg::DATA_W-1:0]  m_tdata,   // x_out, y_out, z_out, w_out
    output logic [0:0]                    m_tuser,   // clipped
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apt_pkg::ADDR_W-1:0]    paddr,
    input  logic [apt_pkg::REG_W-1:0]     pwdata,
    output logic [apt_pkg::REG_W-1:0]     prdata,
    output logic                          pready
);
    import apt_pkg::*;

    // stage 0: input register
    tag_t  tag0_reg;
    tag_t  tag0_next;
    vec_t  vec0_reg;
    vec_t  vec0_next;

    mat_t  coef;
    logic  mul_ready;
    tag_t  tag1;
    pmat_t prod1;
    logic  acc_ready;

    assign pready   = 1'b1;
    assign s_tready = !tag0_reg.valid | mul_ready;

    // decode action; an undefined action makes a bubble
    always_comb begin
        tag0_next = '0;
        case (action_t'(s_tuser))
            ACT_AFFINE: begin
                tag0_next.valid  = s_tvalid;
                tag0_next.affine = 1'b1;
            end
            ACT_FULL: begin
                tag0_next.valid = s_tvalid;
                tag0_next.full  = 1'b1;
            end
            ACT_LINEAR: begin
                tag0_next.valid = s_tvalid;
            end
            default: begin
                tag0_next.valid = 1'b0;
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            vec0_next[k] = to_coord(s_tdata[k*DATA_W +: DATA_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg <= '0;
        end else if (s_tready) begin
            tag0_reg <= tag0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && tag0_next.valid) begin
            vec0_reg <= vec0_next;
        end
    end

    // coefficient registers; the user must write them only while the pipeline is idle (the block does not enforce it)
    apt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .coef    (coef)
    );

    // stage 1: products
    apt_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tag    (tag0_reg),
        .in_vec    (vec0_reg),
        .coef      (coef),
        .in_ready  (mul_ready),
        .out_ready (acc_ready),
        .out_tag   (tag1),
        .out_prod  (prod1)
    );

    // stages 2 and 3: sums, rounding, saturation, output register
    apt_acc u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (tag1),
        .in_prod  (prod1),
        .in_ready (acc_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sv/apt_regs.sv -----
module apt_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [apt_pkg::ADDR_W-1:0] paddr,
    input  logic [apt_pkg::REG_W-1:0]  pwdata,
    output logic [apt_pkg::REG_W-1:0]  prdata,
    output apt_pkg::mat_t              coef
);
    import apt_pkg::*;

    logic [REG_W-1:0] regs_reg [NUM_REGS];
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel & penable & pwrite;
    assign prdata = regs_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= REG_RESET[i];
            end
        end else if (wr_en) begin
            regs_reg[idx] <= pwdata;
        end
    end

    // even column in the low half, odd column in the high half
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                if (k % 2 == 1) begin
                    coef[r][k] = coord_t'(regs_reg[r*2 + k/2][32 +: COORD_WIDTH]);
                end else begin
                    coef[r][k] = coord_t'(regs_reg[r*2 + k/2][0 +: COORD_WIDTH]);
                end
            end
        end
    end

endmodule

// ----- sv/apt_mul.sv -----
module apt_mul (
    input  logic          aclk,
    input  logic          aresetn,
    input  apt_pkg::tag_t in_tag,
    input  apt_pkg::vec_t in_vec,
    input  apt_pkg::mat_t coef,
    output logic          in_ready,
    input  logic          out_ready,
    output apt_pkg::tag_t out_tag,
    output apt_pkg::pmat_t out_prod
);
    import apt_pkg::*;

    tag_t  tag_reg;
    pmat_t prod_reg;
    pmat_t prod_next;

    assign in_ready = !tag_reg.valid | out_ready;
    assign out_tag  = tag_reg;
    assign out_prod = prod_reg;

    // 16 products; column 3 is w product, translation scaled to the
    // product format, or zero
    always_comb begin
        logic signed [2*COORD_WIDTH-1:0] mul [4][4];
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                mul[r][k] = coef[r][k] * in_vec[k];
            end
            for (int k = 0; k < 3; k++) begin
                prod_next[r][k] = prod_t'(mul[r][k]);
            end
            if (in_tag.full) begin
                prod_next[r][3] = prod_t'(mul[r][3]);
            end else if (in_tag.affine) begin
                prod_next[r][3] = prod_t'(coef[r][3]) <<< FRAC_BITS;
            end else begin
                prod_next[r][3] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (in_ready) begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_tag.valid) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ----- sv/apt_acc.sv -----
module apt_acc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  apt_pkg::tag_t                 in_tag,
    input  apt_pkg::pmat_t                in_prod,
    output logic                          in_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [4*apt_pkg::DATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser
);
    import apt_pkg::*;

    localparam sum_t HALF   = sum_t'(64'sd1 <<< (FRAC_BITS - 1));
    localparam sum_t SAT_HI = sum_t'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam sum_t SAT_LO = -SAT_HI - sum_t'(1);

    tag_t   tag2_reg;
    pairs_t pairs_reg;
    pairs_t pairs_next;

    logic                     out_valid_reg;
    logic [4*DATA_W-1:0]      data_reg;
    logic [4*DATA_W-1:0]      data_next;
    logic                     clip_reg;
    logic                     clip_next;
    logic                     out_ready;

    assign out_ready = !out_valid_reg | m_tready;
    assign in_ready  = !tag2_reg.valid | out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = data_reg;
    assign m_tuser   = clip_reg;

    // stage 2: two partial sums per row
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            pairs_next[r][0] = sum_t'(in_prod[r][0]) + sum_t'(in_prod[r][1]);
            pairs_next[r][1] = sum_t'(in_prod[r][2]) + sum_t'(in_prod[r][3]);
        end
    end

    // stage 3: row sum, round half up, saturate
    always_comb begin
        sum_t                     tot [4];
        sum_t                     shr [4];
        logic [3:0]               sat;
        coord_t                   res [4];
        logic signed [DATA_W-1:0] ext [4];
        for (int r = 0; r < 4; r++) begin
            tot[r] = pairs_reg[r][0] + pairs_reg[r][1] + HALF;
            shr[r] = tot[r] >>> FRAC_BITS;
            if (shr[r] > SAT_HI) begin
                res[r] = coord_t'(SAT_HI[COORD_WIDTH-1:0]);
                sat[r] = 1'b1;
            end else if (shr[r] < SAT_LO) begin
                res[r] = coord_t'(SAT_LO[COORD_WIDTH-1:0]);
                sat[r] = 1'b1;
            end else begin
                res[r] = coord_t'(shr[r][COORD_WIDTH-1:0]);
                sat[r] = 1'b0;
            end
            ext[r] = DATA_W'(res[r]);
        end
        if (!tag2_reg.full) begin
            ext[3] = '0;
        end
        clip_next = sat[0] | sat[1] | sat[2] | (tag2_reg.full & sat[3]);
        data_next = {ext[3], ext[2], ext[1], ext[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                tag2_reg <= in_tag;
            end
            if (out_ready) begin
                out_valid_reg <= tag2_reg.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_tag.valid) begin
            pairs_reg <= pairs_next;
        end
        if (out_ready && tag2_reg.valid) begin
            data_reg <= data_next;
            clip_reg <= clip_next;
        end
    end

endmodule

// ----- sv/apt_checker.sv -----
module apt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [4*apt_pkg::DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          pready
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a free output never stalls the input
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind affine_point_transform apt_checker u_apt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apt_pkg::*;

    // tuser code that the block takes and drops without a result
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    // Full-precision row sum: up to 4 products of 64 bits, or 3 plus a scaled translation
    typedef logic signed [71:0] wide_t;

    localparam wide_t COORD_MAX = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam wide_t COORD_MIN = -COORD_MAX - 1;

    localparam coord_t Q_MAX  = 32'sh7FFF_FFFF;
    localparam coord_t Q_MIN  = 32'sh8000_0000;
    localparam coord_t Q_ONE  = 32'sh0001_0000;
    localparam coord_t Q_HALF = 32'sh0000_8000;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC,
        RX_BLOCKED
    } rx_mode_t;

    typedef struct {
        coord_t comp [4];
        logic   clipped;
    } point_result_t;

    // Predicts each transformed point from its own copy of the matrix and
    // checks the results in transfer order.
    class transform_scoreboard;
        logic [REG_W-1:0] coef_regs [NUM_REGS];
        point_result_t    pending_points [$];
        int               errors;

        function new();
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_regs[i] = REG_RESET[i];
            end
            errors = 0;
        endfunction

        function void set_reg(int idx, logic [REG_W-1:0] val);
            coef_regs[idx] = val;
        endfunction

        // bits 31..0 hold the even column, bits 63..32 the odd one
        function coord_t coef(int row, int col);
            logic [REG_W-1:0] r;
            r = coef_regs[row * 2 + col / 2];
            return (col % 2 == 1) ? coord_t'(r[63:32]) : coord_t'(r[31:0]);
        endfunction

        function void note_point(logic [1:0] act, logic [4*DATA_W-1:0] data);
            coord_t        v [4];
            point_result_t e;
            wide_t         acc;
            wide_t         rounded;
            int            nrows;
            if (act == ACT_UNDEFINED) return;
            for (int k = 0; k < 4; k++) begin
                v[k] = coord_t'(data[DATA_W*k +: COORD_WIDTH]);
                e.comp[k] = '0;
            end
            e.clipped = 1'b0;
            nrows = (action_t'(act) == ACT_FULL) ? 4 : 3;
            for (int r = 0; r < nrows; r++) begin
                acc = '0;
                for (int k = 0; k < nrows; k++) begin
                    acc += wide_t'(coef(r, k)) * wide_t'(v[k]);
                end
                if (action_t'(act) == ACT_AFFINE) begin
                    acc += wide_t'(coef(r, 3)) <<< FRAC_BITS;
                end
                // nearest, ties toward plus infinity
                rounded = (acc + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                if (rounded > COORD_MAX) begin
                    rounded = COORD_MAX;
                    e.clipped = 1'b1;
                end else if (rounded < COORD_MIN) begin
                    rounded = COORD_MIN;
                    e.clipped = 1'b1;
                end
                e.comp[r] = coord_t'(rounded);
            end
            pending_points.push_back(e);
        endfunction

        function void check_result(logic [4*DATA_W-1:0] data, logic clipped);
            point_result_t e;
            logic          bad;
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: result with nothing pending: data=%h clipped=%b",
                             $time, data, clipped);
                end
                return;
            end
            e = pending_points.pop_front();
            bad = (clipped !== e.clipped);
            for (int k = 0; k < 4; k++) begin
                if (data[DATA_W*k +: DATA_W] !== e.comp[k]) bad = 1'b1;
            end
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch exp x=%h y=%h z=%h w=%h clip=%b", $time,
                             e.comp[0], e.comp[1], e.comp[2], e.comp[3], e.clipped);
                    $display("%0t:          got x=%h y=%h z=%h w=%h clip=%b", $time,
                             data[31:0], data[63:32], data[95:64], data[127:96],
                             clipped);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [4*DATA_W-1:0]    s_tdata  = '0;   // x_in, y_in, z_in, w_in
    logic [1:0]             s_tuser  = '0;   // action
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [4*DATA_W-1:0]    m_tdata;         // x_out, y_out, z_out, w_out
    logic [0:0]             m_tuser;         // clipped
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [REG_W-1:0]       pwdata   = '0;
    logic [REG_W-1:0]       prdata;
    logic                   pready;

    affine_point_transform dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    transform_scoreboard sb = new();

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Transfer monitor. Everything is driven by nonblocking assignments at
    // the rising edge, so the values seen here are the ones the edge used.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_point(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a stall pattern chosen at random, switched when its count runs out
    // ------------------------------------------------------------------
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 4));
            rx_left <= $urandom_range(64, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_MOSTLY:   m_tready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE:   m_tready <= ($urandom_range(0, 9) < 3);
            RX_PERIODIC: m_tready <= (rx_left % 5 == 0);
            default:     m_tready <= (rx_left % 32 >= 20);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int     burst_left = 0;
    bit     tx_held    = 1'b0;   // s_tvalid stays high for the next transfer
    coord_t mat_next [4][4];

    task automatic send_point(input logic [1:0] act, input coord_t x, input coord_t y,
                              input coord_t z, input coord_t w);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {w, z, y, x};
        tx_held  = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // occasional long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 24);
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            tx_held  = 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Must run in the step of the last transfer, or the stale item repeats
    task automatic release_sender();
        if (tx_held) begin
            s_tvalid <= 1'b0;
            tx_held  = 1'b0;
        end
    endtask

    // Wait for every expected point, bounded so a lost result cannot hang
    task automatic drain_points();
        int guard;
        guard = 0;
        // wait on the clock first, so the monitor has noted the last transfer
        @(posedge aclk);
        while (sb.pending_points.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic reg_write(input int idx, input logic [REG_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Pause the stream until idle, let dropped items clear, load mat_next
    task automatic load_matrix();
        release_sender();
        drain_points();
        repeat (8) @(posedge aclk);
        for (int r = 0; r < 4; r++) begin
            reg_write(r * 2,     {mat_next[r][1], mat_next[r][0]});
            reg_write(r * 2 + 1, {mat_next[r][3], mat_next[r][2]});
        end
        @(posedge aclk);
    endtask

    task automatic fill_matrix(input coord_t c);
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) mat_next[r][k] = c;
        end
    endtask

    // Mix of magnitudes: full range, moderate, small, and the edge values
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0, 1:    return coord_t'($urandom);
            2:       return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
            3:       return coord_t'(int'($urandom_range(0, 33554432)) - 16777216);
            4: begin
                case ($urandom_range(0, 4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return coord_t'(1);
                    default: return coord_t'(-1);
                endcase
            end
            default: return coord_t'(int'($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    function automatic logic [1:0] rand_action();
        if ($urandom_range(0, 19) == 0) return ACT_UNDEFINED;
        return 2'($urandom_range(0, 2));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [1:0] act;
        int         sent;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Identity matrix from reset: x, y and z pass through unchanged, w only for full
        send_point(ACT_AFFINE, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(ACT_AFFINE, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(ACT_FULL,   Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(ACT_FULL,   Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(ACT_LINEAR, 32'sh1234_5678, 32'sh8765_4321,
                   32'shDEAD_BEEF, 32'sh0F0F_0F0F);
        send_point(ACT_UNDEFINED, Q_MAX, Q_MIN, Q_MAX, Q_MIN);   // dropped
        send_point(ACT_AFFINE, '0, '0, '0, '0);

        // Rounding ties and rounding that pushes into saturation:
        // +0.5 ulp rounds up, -0.5 ulp rounds to zero
        fill_matrix('0);
        mat_next[0][0] = Q_HALF;
        mat_next[1][0] = -Q_HALF;
        mat_next[2][0] = Q_ONE + Q_HALF;
        mat_next[0][3] = Q_MAX;
        mat_next[1][3] = Q_MIN;
        mat_next[2][3] = coord_t'(1);
        mat_next[3][0] = Q_HALF;
        mat_next[3][1] = Q_HALF;
        mat_next[3][2] = -Q_HALF;
        mat_next[3][3] = Q_HALF;
        load_matrix();
        send_point(ACT_LINEAR, coord_t'(1), '0, '0, '0);
        send_point(ACT_LINEAR, coord_t'(-1), '0, '0, '0);
        send_point(ACT_AFFINE, coord_t'(1), '0, '0, '0);
        send_point(ACT_FULL,   coord_t'(1), coord_t'(1), coord_t'(1), coord_t'(1));
        send_point(ACT_LINEAR, coord_t'(3), '0, '0, '0);

        // Largest positive coefficients: saturation both ways
        fill_matrix(Q_MAX);
        load_matrix();
        send_point(ACT_AFFINE, Q_MAX, Q_MAX, Q_MAX, '0);
        send_point(ACT_FULL,   Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(ACT_LINEAR, Q_MIN, Q_MAX, '0, Q_MAX);

        // Most negative coefficients: min * min sums overflow the widest terms
        fill_matrix(Q_MIN);
        load_matrix();
        send_point(ACT_FULL,   Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(ACT_AFFINE, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(ACT_LINEAR, coord_t'(1), coord_t'(1), coord_t'(1), '0);

        // Random phases, each with a fresh matrix
        for (int phase = 0; phase < 10; phase++) begin
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 4; k++) begin
                    case (phase % 5)
                        0:       mat_next[r][k] = coord_t'($urandom);
                        1:       mat_next[r][k] =
                                     coord_t'(int'($urandom_range(0, 262144)) - 131072);
                        2:       mat_next[r][k] = rand_coord();
                        3:       mat_next[r][k] = ($urandom_range(0, 1) == 1) ? Q_MAX
                                                                             : Q_MIN;
                        default: mat_next[r][k] = (r == k) ? Q_ONE
                                     : coord_t'(int'($urandom_range(0, 8192)) - 4096);
                    endcase
                end
            end
            load_matrix();
            sent = 0;
            while (sent < 175) begin
                act = rand_action();
                send_point(act, rand_coord(), rand_coord(), rand_coord(), rand_coord());
                if (act != ACT_UNDEFINED) sent++;
            end
        end

        // Wind down: empty the pipeline, then wait for strays
        release_sender();
        drain_points();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_points.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run
    initial begin
        #5000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
